@@ sv/lss_pkg.sv @@
// ----------------------------------------------------------------------------
// lss_pkg: shared codes for the LIFO stack with search
// Action and status encodings used across the stack block.
// ----------------------------------------------------------------------------
package lss_pkg;

  localparam int WordW = 32;

  localparam logic [1:0] ACT_PUSH   = 2'd0;
  localparam logic [1:0] ACT_POP    = 2'd1;
  localparam logic [1:0] ACT_SEARCH = 2'd2;
  localparam logic [1:0] ACT_DUMP   = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_EMPTY    = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

endpackage

@@ sv/lifo_stack_with_search.sv @@
// ----------------------------------------------------------------------------
// lifo_stack_with_search: bounded LIFO stack of signed words with search
// Push, pop, search from top and dump of all entries over one RAM.
// ----------------------------------------------------------------------------
// The stack holds up to DEPTH signed 32-bit words in a RAM with a registered
// read port; one transaction is worked on at a time and in_stall stays high
// until its final result has been placed in the output register. Push, an
// overflowing push, and any action on an empty stack are accepted and then
// answered from the reply state. Pop reads the top entry in the accept cycle
// and returns it from the check state. Search walks the entries from the
// top, one RAM read and one 32-bit compare per cycle, then replies from the
// reply state with the match position counted from the top, starting at one,
// or with not-found status. Dump emits one result per cycle from top to
// bottom while the output side takes them, with last set on the bottom entry.
// The RAM read port and the single comparator set this pace. A finished
// result waits in the output register while the block goes on with the next
// step; an output stall pauses the dump walk and holds a pop result or a
// pending single reply until the register frees.
// ----------------------------------------------------------------------------
module lifo_stack_with_search #(
  parameter int DEPTH = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [1:0]                         action,
  input  logic signed [lss_pkg::WordW-1:0]   value,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [1:0]                         status,
  output logic signed [lss_pkg::WordW-1:0]   word,
  output logic [$clog2(DEPTH+1)-1:0]         position,
  output logic                               last
);

  localparam int AddrW = $clog2(DEPTH);
  localparam int CntW  = $clog2(DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_CHECK = 3'b010,
    S_REPLY = 3'b100
  } state_t;

  state_t state, state_next;

  // stack occupancy and walk offset from the top
  logic [CntW-1:0]  fill_count, fill_count_next;
  logic [AddrW-1:0] idx, idx_next;

  // latched transaction
  logic [1:0]                act, act_next;
  logic [lss_pkg::WordW-1:0] key, key_next;

  // pending single result for the reply state
  logic [1:0]      res_status, res_status_next;
  logic [CntW-1:0] res_pos, res_pos_next;

  // output register load
  logic                      out_free;
  logic                      out_load;
  logic [1:0]                ld_status;
  logic [lss_pkg::WordW-1:0] ld_word;
  logic [CntW-1:0]           ld_pos;
  logic                      ld_last;

  // RAM ports
  logic                      ram_we, ram_re;
  logic [AddrW-1:0]          ram_waddr, ram_raddr;
  logic [lss_pkg::WordW-1:0] ram_rdata;
  logic [AddrW-1:0]          rd_idx;

  logic in_accept;
  logic is_empty, is_full, at_bottom, hit;

  assign in_stall  = (state != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  assign is_empty  = (fill_count == '0);
  assign is_full   = (fill_count == CntW'(DEPTH));
  assign at_bottom = ((CntW'(idx) + CntW'(1)) == fill_count);
  assign hit       = (ram_rdata == key);

  // read the top on accept; step one entry down while walking
  assign rd_idx    = (state == S_CHECK) ? (idx + AddrW'(1)) : '0;
  assign ram_raddr = AddrW'(fill_count - CntW'(1)) - rd_idx;
  assign ram_waddr = AddrW'(fill_count);

  lss_ram #(
    .WIDTH (lss_pkg::WordW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (value),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_next      = state;
    fill_count_next = fill_count;
    idx_next        = idx;
    act_next        = act;
    key_next        = key;
    res_status_next = res_status;
    res_pos_next    = res_pos;
    ram_we          = 1'b0;
    ram_re          = 1'b0;
    out_load        = 1'b0;
    ld_status       = lss_pkg::ST_OK;
    ld_word         = '0;
    ld_pos          = '0;
    ld_last         = 1'b1;

    case (state)
      S_IDLE: begin
        if (in_accept) begin
          act_next     = action;
          key_next     = value;
          idx_next     = '0;
          res_pos_next = '0;
          if (action == lss_pkg::ACT_PUSH) begin
            if (is_full) begin
              res_status_next = lss_pkg::ST_OVERFLOW;
            end else begin
              ram_we          = 1'b1;
              fill_count_next = fill_count + CntW'(1);
              res_status_next = lss_pkg::ST_OK;
            end
            state_next = S_REPLY;
          end else if (is_empty) begin
            res_status_next = lss_pkg::ST_EMPTY;
            state_next      = S_REPLY;
          end else begin
            ram_re     = 1'b1;
            state_next = S_CHECK;
          end
        end
      end

      S_CHECK: begin
        case (act)
          lss_pkg::ACT_POP: begin
            if (out_free) begin
              out_load        = 1'b1;
              ld_word         = ram_rdata;
              fill_count_next = fill_count - CntW'(1);
              state_next      = S_IDLE;
            end
          end
          lss_pkg::ACT_SEARCH: begin
            if (hit) begin
              res_status_next = lss_pkg::ST_OK;
              res_pos_next    = CntW'(idx) + CntW'(1);
              state_next      = S_REPLY;
            end else if (at_bottom) begin
              res_status_next = lss_pkg::ST_NOTFOUND;
              state_next      = S_REPLY;
            end else begin
              ram_re   = 1'b1;
              idx_next = idx + AddrW'(1);
            end
          end
          lss_pkg::ACT_DUMP: begin
            // hold the read data while the output side stalls
            if (out_free) begin
              out_load = 1'b1;
              ld_word  = ram_rdata;
              ld_last  = at_bottom;
              if (at_bottom) begin
                state_next = S_IDLE;
              end else begin
                ram_re   = 1'b1;
                idx_next = idx + AddrW'(1);
              end
            end
          end
          default: begin
            state_next = S_IDLE;
          end
        endcase
      end

      S_REPLY: begin
        if (out_free) begin
          out_load   = 1'b1;
          ld_status  = res_status;
          ld_pos     = res_pos;
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      fill_count <= '0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      fill_count <= fill_count_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx        <= idx_next;
    act        <= act_next;
    key        <= key_next;
    res_status <= res_status_next;
    res_pos    <= res_pos_next;
    if (out_load) begin
      status   <= ld_status;
      word     <= ld_word;
      position <= ld_pos;
      last     <= ld_last;
    end
  end

endmodule

@@ sv/lss_ram.sv @@
// ----------------------------------------------------------------------------
// lss_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module lss_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // hold read data until the next read
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
